>>> hdl/ptpu_pkg.sv
package ptpu_pkg;

  localparam int MAX_ROW_BYTES  = 16384;
  localparam int MAX_EDGE       = 4096;
  localparam int PNG_MODE_FIRST = 10;
  localparam int PNG_MODE_LAST  = 15;

  localparam int ROW_AW = $clog2(MAX_ROW_BYTES);
  localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int EDGE_W = $clog2(MAX_EDGE + 1);

  localparam int REG_DIM_W  = 13;
  localparam int REG_CH_W   = 3;
  localparam int REG_MODE_W = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_MODE     = 2'd3
  } reg_index_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FILTER = 2'd1;
  localparam logic [1:0] ST_BAD_MODE   = 2'd2;
  localparam logic [1:0] ST_SHORT      = 2'd3;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  localparam logic [REG_MODE_W-1:0] MODE_HDIFF = 4'd2;

  typedef struct packed {
    logic [2:0]            channels;
    logic [COL_W-1:0]      stride;
    logic [EDGE_W-1:0]     height;
    logic [REG_MODE_W-1:0] mode;
  } cfg_t;

endpackage

>>> hdl/ptpu_if.sv
interface ptpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ptpu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       stream_end;

  modport source(output valid, output out_byte, output byte_valid, output status,
                 output stream_end, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input status,
               input stream_end, output ready);
endinterface

>>> hdl/png_tiff_predictor_undo.sv
// Undoes TIFF horizontal differencing and PNG row filtering on a byte stream.
// Input transactions on stream carry one byte of the decompressed image and a
// last_byte mark; every input transaction yields exactly one transaction on
// result, in order, carrying the rebuilt byte, byte_valid, status and
// stream_end. The user must write the registers through the APB port only
// while no byte is in flight; the block itself does not enforce this.
// A byte accepted at a clock edge is registered into the read stage, where the
// line store is read at the accept edge itself, and then moves into the output
// register. One byte per cycle is sustained while the receiver takes every
// result. The line store is a single memory with one write port and one read
// port, read for a column at accept and written back for the same column when
// an image byte moves into the output register; the rebuilt byte is registered
// as the left neighbour of the next byte of the same channel.
// Reset clears the row and column counters, the sticky error and the valid
// flags of both pipeline stages; the line store keeps its contents and needs no
// clearing pass because the first row of every image ignores what it reads.
// When the receiver stalls, the result is held in the output register and one
// more byte can still be accepted into the read stage; after that stream.ready
// falls until the output register is taken.
module png_tiff_predictor_undo import ptpu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ptpu_in_if.sink            stream,
  ptpu_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef struct packed {
    logic [7:0]        data;
    logic              img;
    logic [1:0]        slot;
    logic              has_left;
    logic              b_use;
    logic              hdiff;
    logic              png;
    logic [2:0]        filter;
    logic [1:0]        status;
    logic              last;
    logic [ROW_AW-1:0] addr;
  } stage_t;

  cfg_t cfg;

  logic [COL_W-1:0]  column_index, column_index_next, col_inc;
  logic [EDGE_W-1:0] row_count, row_count_next;
  logic [2:0]        row_filter, row_filter_next;
  logic              awaiting_filter_byte, awaiting_filter_byte_next;
  logic [1:0]        error_code, error_code_next;

  logic [7:0] left_bytes [4];
  logic [7:0] upper_left_bytes [4];

  logic       png, supported, accept, s2_adv, wr;
  stage_t     s0, s1;
  logic       s1_valid, s1_fwd;
  logic [7:0] s1_fwd_data;
  logic [7:0] ram_rdata, rb, a, b, c, v;
  logic [8:0] avg_sum;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       stream_end;

  function automatic logic [1:0] mod3(input logic [ROW_AW-1:0] x);
    logic [4:0] s;
    logic [3:0] t1;
    logic [2:0] t2;
    s = '0;
    for (int i = 0; i < ROW_AW; i += 2) begin
      s = s + 5'(x[i +: 2]);
    end
    t1 = 4'(s[4:2]) + 4'(s[1:0]);
    t2 = 3'(t1[3:2]) + 3'(t1[1:0]);
    return (t2 >= 3'd3) ? 2'(t2 - 3'd3) : t2[1:0];
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] pa_in, input logic [7:0] pb_in,
                                       input logic [7:0] pc_in);
    logic signed [9:0] db, da, pa, pb, pc;
    logic [7:0]        r;
    db = signed'(10'(pb_in)) - signed'(10'(pc_in));
    da = signed'(10'(pa_in)) - signed'(10'(pc_in));
    pa = (db < 0) ? -db : db;
    pb = (da < 0) ? -da : da;
    pc = (db + da < 0) ? -(db + da) : (db + da);
    if (pa <= pb && pa <= pc) begin
      r = pa_in;
    end else if (pb <= pc) begin
      r = pb_in;
    end else begin
      r = pc_in;
    end
    return r;
  endfunction

  ptpu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s2_adv       = !out_valid || result.ready;
  assign stream.ready = !s1_valid || s2_adv;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    png = (int'(cfg.mode) >= PNG_MODE_FIRST) && (int'(cfg.mode) <= PNG_MODE_LAST);
    supported = (cfg.mode <= MODE_HDIFF) || png;

    column_index_next         = column_index;
    row_count_next            = row_count;
    row_filter_next           = row_filter;
    awaiting_filter_byte_next = awaiting_filter_byte;
    error_code_next           = error_code;
    col_inc                   = COL_W'(column_index + 1'b1);

    s0.data     = stream.data_byte;
    s0.img      = 1'b0;
    s0.has_left = column_index >= COL_W'(cfg.channels);
    s0.b_use    = row_count != '0;
    s0.hdiff    = cfg.mode == MODE_HDIFF;
    s0.png      = png;
    s0.filter   = row_filter;
    s0.last     = stream.last_byte;
    s0.addr     = column_index[ROW_AW-1:0];
    unique case (cfg.channels)
      3'd2:    s0.slot = {1'b0, column_index[0]};
      3'd3:    s0.slot = mod3(column_index[ROW_AW-1:0]);
      3'd4:    s0.slot = column_index[1:0];
      default: s0.slot = 2'd0;
    endcase

    if (!supported) begin
      if (error_code == ST_OK) begin
        error_code_next = ST_BAD_MODE;
      end
    end else if (row_count < cfg.height) begin
      if (png && awaiting_filter_byte) begin
        if (stream.data_byte > 8'd4) begin
          if (error_code == ST_OK) begin
            error_code_next = ST_BAD_FILTER;
          end
          row_filter_next = FLT_NONE;
        end else begin
          row_filter_next = stream.data_byte[2:0];
        end
        awaiting_filter_byte_next = 1'b0;
      end else begin
        s0.img = 1'b1;
        if (col_inc >= cfg.stride) begin
          column_index_next         = '0;
          row_count_next            = EDGE_W'(row_count + 1'b1);
          awaiting_filter_byte_next = 1'b1;
        end else begin
          column_index_next = col_inc;
        end
      end
    end

    s0.status = error_code_next;
    if (stream.last_byte && error_code_next == ST_OK && row_count_next < cfg.height) begin
      s0.status = ST_SHORT;
    end

    if (stream.last_byte) begin
      column_index_next         = '0;
      row_count_next            = '0;
      row_filter_next           = FLT_NONE;
      awaiting_filter_byte_next = 1'b1;
      error_code_next           = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index         <= '0;
      row_count            <= '0;
      row_filter           <= FLT_NONE;
      awaiting_filter_byte <= 1'b1;
      error_code           <= ST_OK;
    end else if (accept) begin
      column_index         <= column_index_next;
      row_count            <= row_count_next;
      row_filter           <= row_filter_next;
      awaiting_filter_byte <= awaiting_filter_byte_next;
      error_code           <= error_code_next;
    end
  end

  ptpu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (wr),
    .waddr (s1.addr),
    .wdata (v),
    .re    (accept),
    .raddr (s0.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  // A write to the column being read at the same edge is forwarded, since
  // the memory returns the old contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1          <= s0;
      s1_fwd      <= wr && (s1.addr == s0.addr);
      s1_fwd_data <= v;
    end
  end

  always_comb begin
    rb      = s1_fwd ? s1_fwd_data : ram_rdata;
    a       = s1.has_left ? left_bytes[s1.slot] : 8'd0;
    b       = s1.b_use ? rb : 8'd0;
    c       = (s1.has_left && s1.b_use) ? upper_left_bytes[s1.slot] : 8'd0;
    avg_sum = 9'(a) + 9'(b);
    v       = s1.data;
    if (s1.hdiff) begin
      v = s1.data + a;
    end else if (s1.png) begin
      unique case (s1.filter)
        FLT_SUB:   v = s1.data + a;
        FLT_UP:    v = s1.data + b;
        FLT_AVG:   v = s1.data + avg_sum[8:1];
        FLT_PAETH: v = s1.data + paeth(a, b, c);
        default:   v = s1.data;
      endcase
    end
    wr = s1_valid && s1.img && s2_adv;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      left_bytes[s1.slot]       <= v;
      upper_left_bytes[s1.slot] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_byte   <= s1.img ? v : 8'd0;
      byte_valid <= s1.img;
      status     <= s1.status;
      stream_end <= s1.last;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_byte   = out_byte;
  assign result.byte_valid = byte_valid;
  assign result.status     = status;
  assign result.stream_end = stream_end;

endmodule

>>> hdl/ptpu_ram.sv
module ptpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ptpu_cfg.sv
module ptpu_cfg import ptpu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_DIM_W-1:0]  image_width;
  logic [REG_DIM_W-1:0]  image_height;
  logic [REG_CH_W-1:0]   color_channels;
  logic [REG_MODE_W-1:0] predictor_mode;
  logic [EDGE_W-1:0]     width_eff;
  logic [EDGE_W+2:0]     row_bytes;
  reg_index_t            index;

  function automatic logic [EDGE_W-1:0] eff_dim(input logic [REG_DIM_W-1:0] v);
    logic [EDGE_W-1:0] r;
    if (v == '0) begin
      r = EDGE_W'(1);
    end else if (int'(v) > MAX_EDGE) begin
      r = EDGE_W'(MAX_EDGE);
    end else begin
      r = EDGE_W'(v);
    end
    return r;
  endfunction

  assign index  = reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= REG_DIM_W'(1);
      image_height   <= REG_DIM_W'(1);
      color_channels <= REG_CH_W'(1);
      predictor_mode <= REG_MODE_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (index)
        REG_WIDTH:    image_width    <= pwdata[REG_DIM_W-1:0];
        REG_HEIGHT:   image_height   <= pwdata[REG_DIM_W-1:0];
        REG_CHANNELS: color_channels <= pwdata[REG_CH_W-1:0];
        REG_MODE:     predictor_mode <= pwdata[REG_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_WIDTH:    prdata = PDATA_W'(image_width);
      REG_HEIGHT:   prdata = PDATA_W'(image_height);
      REG_CHANNELS: prdata = PDATA_W'(color_channels);
      REG_MODE:     prdata = PDATA_W'(predictor_mode);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    if (color_channels == '0) begin
      cfg.channels = 3'd1;
    end else if (color_channels > 3'd4) begin
      cfg.channels = 3'd4;
    end else begin
      cfg.channels = color_channels;
    end
    width_eff  = eff_dim(image_width);
    row_bytes  = (EDGE_W+3)'(width_eff) * (EDGE_W+3)'(cfg.channels);
    if (int'(row_bytes) > MAX_ROW_BYTES) begin
      cfg.stride = COL_W'(MAX_ROW_BYTES);
    end else begin
      cfg.stride = COL_W'(row_bytes);
    end
    cfg.height = eff_dim(image_height);
    cfg.mode   = predictor_mode;
  end

endmodule

>>> hdl/ptpu_checker.sv
module ptpu_checker import ptpu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] status,
  input logic       stream_end
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(status) && $stable(stream_end))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("nonzero byte on a result without an image byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_SHORT |-> stream_end)
    else $error("short stream reported before the end of the stream");

endmodule

bind png_tiff_predictor_undo ptpu_checker u_ptpu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_byte   (result.out_byte),
  .byte_valid (result.byte_valid),
  .status     (result.status),
  .stream_end (result.stream_end)
);
